/* hdl/tcgp_pkg.sv */
// ----------------------------------------------------------------------------
// tcgp_pkg
// Shared widths, request and register codes, and the command and status
// structs that join the ground probe controller and datapath.
// ----------------------------------------------------------------------------
package tcgp_pkg;

    localparam int RowW    = 5;     // map row
    localparam int ColW    = 8;     // map column / tile column
    localparam int TaddrW  = 13;    // tile store byte address
    localparam int ValW    = 8;     // write value, tile id
    localparam int WxW     = 16;    // world x
    localparam int GyW     = 15;    // ground y
    localparam int PyW     = 3;     // pixel row inside a tile
    localparam int MapAW   = RowW + ColW;
    localparam int DivW    = WxW - 3;   // world x in whole tiles
    localparam int StepW   = 4;         // counts the DivW remainder steps
    localparam int WidthW  = 9;
    localparam int HeightW = 6;
    localparam int ColourW = 4;
    localparam int CfgAW   = 2;
    localparam int CfgDW   = 15;
    localparam int InDW    = 56;
    localparam int OutDW   = 16;

    localparam logic [WidthW-1:0]  MaxMapCols  = 9'd256;
    localparam logic [HeightW-1:0] MaxMapRows  = 6'd32;
    localparam logic [StepW-1:0]   LastStep    = 4'(DivW - 1);

    localparam logic [WidthW-1:0]  WidthRst    = 9'd256;
    localparam logic [HeightW-1:0] HeightRst   = 6'd32;
    localparam logic [ColourW-1:0] ColourRst   = 4'd2;
    localparam logic [GyW-1:0]     NoGroundRst = 15'd239;

    typedef enum logic [1:0] {
        REQ_MAP_WR  = 2'd0,
        REQ_TILE_WR = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [CfgAW-1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1,
        CFG_GROUND     = 2'd2,
        CFG_NO_GROUND  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic ld_query;
        logic map_wr;
        logic tile_wr;
        logic mod_step;
        logic map_rd;
        logic row_inc;
        logic pix_clr;
        logic pix_rd;
        logic pix_inc;
        logic res_load;
        logic res_hit;
    } cmd_t;

    typedef struct packed {
        logic mod_last;
        logic h_zero;
        logic id_zero;
        logic row_last;
        logic pix_last;
        logic pix_match;
    } sts_t;

endpackage

/* hdl/tcgp_ctrl.sv */
// ----------------------------------------------------------------------------
// tcgp_ctrl
// Sequencer for the ground probe: takes beats, runs the tile column
// remainder, walks map rows and pixel rows, and hands off the result.
// ----------------------------------------------------------------------------
module tcgp_ctrl
    import tcgp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,
    output logic       m_tvalid,
    input  logic       m_tready,
    output cmd_t       cmd,
    input  sts_t       sts
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MOD    = 8'b0000_0010,
        ST_MAPRD  = 8'b0000_0100,
        ST_MAPCHK = 8'b0000_1000,
        ST_PIXRD  = 8'b0001_0000,
        ST_PIXCHK = 8'b0010_0000,
        ST_FHIT   = 8'b0100_0000,
        ST_FMISS  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;
    assign m_tvalid = mvalid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_t'(s_tuser))
                        REQ_MAP_WR:  cmd.map_wr = 1'b1;
                        REQ_TILE_WR: cmd.tile_wr = 1'b1;
                        REQ_QUERY:
                        begin
                            cmd.ld_query = 1'b1;
                            state_next   = ST_MOD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                    state_next = sts.h_zero ? ST_FMISS : ST_MAPRD;
            end
            ST_MAPRD:
            begin
                cmd.map_rd = 1'b1;
                state_next = ST_MAPCHK;
            end
            ST_MAPCHK:
            begin
                if (!sts.id_zero)
                begin
                    cmd.pix_clr = 1'b1;
                    state_next  = ST_PIXRD;
                end
                else if (sts.row_last)
                    state_next = ST_FMISS;
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = ST_MAPRD;
                end
            end
            ST_PIXRD:
            begin
                cmd.pix_rd = 1'b1;
                state_next = ST_PIXCHK;
            end
            ST_PIXCHK:
            begin
                if (sts.pix_match)
                    state_next = ST_FHIT;
                else if (!sts.pix_last)
                begin
                    cmd.pix_inc = 1'b1;
                    state_next  = ST_PIXRD;
                end
                else if (sts.row_last)
                    state_next = ST_FMISS;
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = ST_MAPRD;
                end
            end
            ST_FHIT, ST_FMISS:
            begin
                // hold the answer until the output register is free
                if (out_free)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_hit  = (state_reg == ST_FHIT);
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (cmd.res_load)
            mvalid_next = 1'b1;
        else if (m_tready)
            mvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

/* hdl/tcgp_dp.sv */
// ----------------------------------------------------------------------------
// tcgp_dp
// Ground probe datapath: configuration registers, map and tile memories,
// bit-serial tile column remainder, scan counters and result register.
// ----------------------------------------------------------------------------
module tcgp_dp
    import tcgp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CfgAW-1:0]  cfg_addr,
    input  logic [CfgDW-1:0]  cfg_wdata,
    input  logic [RowW-1:0]   map_row,
    input  logic [ColW-1:0]   map_col,
    input  logic [TaddrW-1:0] tile_byte_addr,
    input  logic [ValW-1:0]   write_value,
    input  logic [WxW-1:0]    world_x,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic [GyW-1:0]    ground_y,
    output logic              found
);

    logic [WidthW-1:0]  width_reg;
    logic [HeightW-1:0] height_reg;
    logic [ColourW-1:0] colour_reg;
    logic [GyW-1:0]     no_ground_reg;

    logic [ValW-1:0] map_mem  [2**MapAW];
    logic [ValW-1:0] tile_mem [2**TaddrW];
    logic [ValW-1:0] id_reg;
    logic [ValW-1:0] pix_reg;

    logic [DivW-1:0]   div_reg;
    logic [WidthW-1:0] rem_reg;
    logic [StepW-1:0]  step_reg;
    logic [2:0]        lx_reg;
    logic [RowW-1:0]   row_reg;
    logic [PyW-1:0]    py_reg;
    logic [GyW-1:0]    gy_reg;
    logic              found_reg;

    logic [WidthW-1:0]  w_eff;
    logic [HeightW-1:0] h_eff;
    logic [WidthW:0]    trial;
    logic               trial_ge;
    logic [WidthW:0]    trial_sub;
    logic [ColourW-1:0] nibble;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WidthRst;
            height_reg    <= HeightRst;
            colour_reg    <= ColourRst;
            no_ground_reg <= NoGroundRst;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_MAP_WIDTH:  width_reg     <= cfg_wdata[WidthW-1:0];
                CFG_MAP_HEIGHT: height_reg    <= cfg_wdata[HeightW-1:0];
                CFG_GROUND:     colour_reg    <= cfg_wdata[ColourW-1:0];
                CFG_NO_GROUND:  no_ground_reg <= cfg_wdata[GyW-1:0];
                default: ;
            endcase
        end
    end

    // zero width acts as one, oversize settings clamp to the store size
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WidthW'(1);
        else if (width_reg > MaxMapCols)
            w_eff = MaxMapCols;
        else
            w_eff = width_reg;
        h_eff = (height_reg > MaxMapRows) ? MaxMapRows : height_reg;
    end

    // one restoring remainder step per cycle, MSB of the tile x first
    assign trial     = {rem_reg, div_reg[DivW-1]};
    assign trial_ge  = trial >= {1'b0, w_eff};
    assign trial_sub = trial - {1'b0, w_eff};

    always_ff @(posedge clk)
    begin
        if (cmd.map_wr)
            map_mem[{map_row, map_col}] <= write_value;
        if (cmd.map_rd)
            id_reg <= map_mem[{row_reg, rem_reg[ColW-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tile_wr)
            tile_mem[tile_byte_addr] <= write_value;
        if (cmd.pix_rd)
            pix_reg <= tile_mem[{id_reg, py_reg, lx_reg[2:1]}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_query)
        begin
            div_reg  <= world_x[WxW-1:3];
            lx_reg   <= world_x[2:0];
            rem_reg  <= '0;
            step_reg <= '0;
            row_reg  <= '0;
        end
        else if (cmd.mod_step)
        begin
            div_reg  <= {div_reg[DivW-2:0], 1'b0};
            rem_reg  <= trial_ge ? trial_sub[WidthW-1:0] : trial[WidthW-1:0];
            step_reg <= step_reg + StepW'(1);
        end
        else if (cmd.row_inc)
            row_reg <= row_reg + RowW'(1);

        if (cmd.pix_clr)
            py_reg <= '0;
        else if (cmd.pix_inc)
            py_reg <= py_reg + PyW'(1);

        if (cmd.res_load)
        begin
            gy_reg    <= cmd.res_hit ? GyW'({row_reg, py_reg}) : no_ground_reg;
            found_reg <= cmd.res_hit;
        end
    end

    // even x sits in the high nibble
    assign nibble = lx_reg[0] ? pix_reg[3:0] : pix_reg[7:4];

    always_comb
    begin
        sts.mod_last  = (step_reg == LastStep);
        sts.h_zero    = (h_eff == '0);
        sts.id_zero   = (id_reg == '0);
        sts.row_last  = ({1'b0, row_reg} + HeightW'(1)) == h_eff;
        sts.pix_last  = (py_reg == '1);
        sts.pix_match = (nibble == colour_reg);
    end

    assign ground_y = gy_reg;
    assign found    = found_reg;

endmodule

/* hdl/tilemap_column_ground_probe_top.sv */
// ----------------------------------------------------------------------------
// tilemap_column_ground_probe_top
// Tile map column ground probe: loads map cells and tile bytes, and answers
// ground queries with the first ground pixel row below a world x.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_*       in         tuser req_type; tdata map_row..world_x, 56 bits
//  m_*       out        tuser found; tdata ground_y, 16 bits
//  cfg_*     in         one register write per cycle with cfg_we high
//
//  A write beat is taken while idle. A query first runs the tile column
//  remainder (one bit a cycle), then reads each map row and, for a non-empty
//  tile, its pixel rows from the single-port tile memory, and hands off the
//  result once the output register is free; a full miss walks up to 32 rows.
//  Reset clears control and config state; memories hold garbage until written.
//  s_tready is high while idle, even when a result still waits on m_tready.
// ----------------------------------------------------------------------------
module tilemap_column_ground_probe_top
    import tcgp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [1:0] req_type
    input  logic [1:0]       s_tuser,
    // [4:0] map_row, [12:5] map_col, [25:13] tile_byte_addr,
    // [33:26] write_value, [49:34] world_x, [55:50] zero
    input  logic [InDW-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [0] found
    output logic             m_tuser,
    // [14:0] ground_y, [15] zero
    output logic [OutDW-1:0] m_tdata,
    input  logic             cfg_we,
    input  logic [CfgAW-1:0] cfg_addr,
    input  logic [CfgDW-1:0] cfg_wdata
);

    cmd_t           cmd;
    sts_t           sts;
    logic [GyW-1:0] ground_y;

    tcgp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tcgp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .map_row        (s_tdata[4:0]),
        .map_col        (s_tdata[12:5]),
        .tile_byte_addr (s_tdata[25:13]),
        .write_value    (s_tdata[33:26]),
        .world_x        (s_tdata[49:34]),
        .cmd            (cmd),
        .sts            (sts),
        .ground_y       (ground_y),
        .found          (m_tuser)
    );

    assign m_tdata = {1'b0, ground_y};

endmodule
